FILE: rtl/core/srms_pkg.sv
// Shared constants and types for the stereo moving RMS filter.
package srms_pkg;

    // sample and channel geometry
    localparam int DATA_W    = 16;
    localparam int NUM_CH    = 2;
    localparam int RMS_W     = 15;

    // window geometry
    localparam int MAX_HALF  = 127;
    localparam int HALF_W    = 7;
    localparam int LEN_W     = HALF_W + 1;
    localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
    localparam int PTR_W     = $clog2(WIN_DEPTH);

    // arithmetic widths
    localparam int SUM_W     = 38;
    localparam int PROD_W    = 2 * (DATA_W + 1);
    localparam int QUO_W     = 2 * DATA_W - 1;
    localparam int ROOT_W    = DATA_W;
    localparam int SREM_W    = ROOT_W + 1;
    localparam int CNT_W     = 5;

    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(1);
    localparam logic [RMS_W-1:0]  RMS_MAX    = {RMS_W{1'b1}};

    // one stored window entry: left in the low half, right in the high half
    typedef logic [NUM_CH-1:0][DATA_W-1:0] pair_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_FIN
    } state_t;

endpackage

FILE: rtl/core/stereo_moving_rms_top.sv
// Stereo moving RMS filter: window store, running sums, serial divide and square root.
// Each transaction taken on the s_ channel passes through the multiply, accumulate, divide
// (radix-2) and square root (radix-4) states, both lanes in step, before m_valid rises;
// s_ready is low until the FSM is back in idle, so a new transaction waits for the last.
// Reset (aresetn, synchronous): window_half = 1, sums, pointer and window valid bits cleared.
// A write on cfg_wr_en clears the store's valid bits, sums and pointer in the same cycle.
module stereo_moving_rms_top
    import srms_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [HALF_W-1:0]        cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_left_in,
    input  logic signed [DATA_W-1:0] s_right_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [RMS_W-1:0]         m_rms_left,
    output logic [RMS_W-1:0]         m_rms_right
);

    // control
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [HALF_W-1:0]   window_half_reg, window_half_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [WIN_DEPTH-1:0] vld_reg, vld_next;

    logic accept, mul_en, acc_en, div_en, sqrt_en, fin_en;
    logic div_last, sqrt_last;

    // window store
    pair_t               win_mem [WIN_DEPTH];
    pair_t               win_rd_reg;
    logic                old_vld_reg;
    logic [PTR_W-1:0]    p_eff, p_inc;
    logic [LEN_W-1:0]    win_len;

    // per-lane datapath
    logic signed [DATA_W-1:0] smp_reg  [NUM_CH];
    logic signed [DATA_W-1:0] smp_next [NUM_CH];
    logic signed [PROD_W-1:0] prod_reg [NUM_CH];
    logic signed [PROD_W-1:0] prod_next[NUM_CH];
    logic [SUM_W-1:0]         sum_reg  [NUM_CH];
    logic [SUM_W-1:0]         sum_next [NUM_CH];
    logic [LEN_W-1:0]         rem_reg  [NUM_CH];
    logic [LEN_W-1:0]         rem_next [NUM_CH];
    logic [QUO_W-1:0]         dq_reg   [NUM_CH];
    logic [QUO_W-1:0]         dq_next  [NUM_CH];
    logic [2*ROOT_W-1:0]      sx_reg   [NUM_CH];
    logic [2*ROOT_W-1:0]      sx_next  [NUM_CH];
    logic [SREM_W-1:0]        sr_reg   [NUM_CH];
    logic [SREM_W-1:0]        sr_next  [NUM_CH];
    logic [ROOT_W-1:0]        root_reg [NUM_CH];
    logic [ROOT_W-1:0]        root_next[NUM_CH];
    logic [RMS_W-1:0]         rms_reg  [NUM_CH];
    logic [RMS_W-1:0]         rms_next [NUM_CH];

    assign accept    = s_valid & s_ready;
    assign div_last  = (cnt_reg == CNT_W'(QUO_W - 1));
    assign sqrt_last = (cnt_reg == CNT_W'(ROOT_W - 1));
    assign win_len   = {window_half_reg, 1'b1};

    // slot of the oldest entry and the pointer after it
    assign p_eff = (ptr_reg >= win_len) ? '0 : ptr_reg;
    assign p_inc = p_eff + 1'b1;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = ST_DIV;
            ST_DIV: begin
                if (div_last) state_next = ST_SQRT;
            end
            ST_SQRT: begin
                if (sqrt_last) state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state decode
    always_comb begin
        s_ready = 1'b0;
        mul_en  = 1'b0;
        acc_en  = 1'b0;
        div_en  = 1'b0;
        sqrt_en = 1'b0;
        fin_en  = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_MUL:  mul_en  = 1'b1;
            ST_ACC:  acc_en  = 1'b1;
            ST_DIV:  div_en  = 1'b1;
            ST_SQRT: sqrt_en = 1'b1;
            ST_FIN:  fin_en  = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    // control next values
    always_comb begin
        cnt_next         = cnt_reg;
        m_valid_next     = m_valid_reg;
        window_half_next = window_half_reg;
        ptr_next         = ptr_reg;
        vld_next         = vld_reg;

        if (acc_en || (div_en && div_last)) begin
            cnt_next = '0;
        end else if (div_en || sqrt_en) begin
            cnt_next = cnt_reg + 1'b1;
        end

        if (fin_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            window_half_next = cfg_wr_data;
            ptr_next         = '0;
            vld_next         = '0;
        end else if (accept) begin
            ptr_next        = (p_inc >= win_len) ? '0 : p_inc;
            vld_next[p_eff] = 1'b1;
        end
    end

    // lane datapath: difference of squares, running sum, serial divide and root
    always_comb begin
        logic signed [DATA_W-1:0] old_smp;
        logic signed [DATA_W:0]   dif;
        logic signed [DATA_W:0]   tot;
        logic [LEN_W:0]           dsh;
        logic [LEN_W:0]           dsub;
        logic [SREM_W+1:0]        ssh;
        logic [SREM_W+1:0]        trial;
        logic [SREM_W+1:0]        ssub;
        logic                     qbit;

        for (int ch = 0; ch < NUM_CH; ch++) begin
            old_smp = old_vld_reg ? win_rd_reg[ch] : '0;
            dif     = {smp_reg[ch][DATA_W-1], smp_reg[ch]} - {old_smp[DATA_W-1], old_smp};
            tot     = {smp_reg[ch][DATA_W-1], smp_reg[ch]} + {old_smp[DATA_W-1], old_smp};
            dsh     = {rem_reg[ch], dq_reg[ch][QUO_W-1]};
            dsub    = dsh - {1'b0, win_len};
            ssh     = {sr_reg[ch], sx_reg[ch][2*ROOT_W-1 -: 2]};
            trial   = {1'b0, root_reg[ch], 2'b01};
            ssub    = ssh - trial;
            qbit    = 1'b0;

            smp_next[ch]  = smp_reg[ch];
            prod_next[ch] = prod_reg[ch];
            sum_next[ch]  = sum_reg[ch];
            rem_next[ch]  = rem_reg[ch];
            dq_next[ch]   = dq_reg[ch];
            sx_next[ch]   = sx_reg[ch];
            sr_next[ch]   = sr_reg[ch];
            root_next[ch] = root_reg[ch];
            rms_next[ch]  = rms_reg[ch];

            if (accept) begin
                smp_next[ch] = (ch == 0) ? s_left_in : s_right_in;
            end

            // new^2 - old^2 = (new - old) * (new + old)
            if (mul_en) begin
                prod_next[ch] = dif * tot;
            end

            // running sum; the top bits always stay below the length
            if (cfg_wr_en) begin
                sum_next[ch] = '0;
            end else if (acc_en) begin
                sum_next[ch] = sum_reg[ch]
                             + {{(SUM_W-PROD_W){prod_reg[ch][PROD_W-1]}}, prod_reg[ch]};
            end
            if (acc_en) begin
                rem_next[ch] = {1'b0, sum_next[ch][SUM_W-1:QUO_W]};
                dq_next[ch]  = sum_next[ch][QUO_W-1:0];
            end

            // restoring divide, one quotient bit per cycle
            if (div_en) begin
                qbit = (dsh >= {1'b0, win_len});
                rem_next[ch] = qbit ? dsub[LEN_W-1:0] : dsh[LEN_W-1:0];
                dq_next[ch]  = {dq_reg[ch][QUO_W-2:0], qbit};
                if (div_last) begin
                    sx_next[ch]   = {1'b0, dq_next[ch]};
                    sr_next[ch]   = '0;
                    root_next[ch] = '0;
                end
            end

            // square root, two radicand bits per cycle
            if (sqrt_en) begin
                qbit = (ssh >= trial);
                sr_next[ch]   = qbit ? ssub[SREM_W-1:0] : ssh[SREM_W-1:0];
                root_next[ch] = {root_reg[ch][ROOT_W-2:0], qbit};
                sx_next[ch]   = {sx_reg[ch][2*ROOT_W-3:0], 2'b00};
            end

            // output register with saturation
            if (fin_en) begin
                rms_next[ch] = root_reg[ch][ROOT_W-1] ? RMS_MAX : root_reg[ch][RMS_W-1:0];
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            window_half_reg <= HALF_RESET;
            ptr_reg         <= '0;
            vld_reg         <= '0;
        end else begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            m_valid_reg     <= m_valid_next;
            window_half_reg <= window_half_next;
            ptr_reg         <= ptr_next;
            vld_reg         <= vld_next;
        end
    end

    // running sums are state and clear on reset
    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (!aresetn) begin
                sum_reg[ch] <= '0;
            end else begin
                sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    // lane payload registers
    always_ff @(posedge aclk) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            smp_reg[ch]  <= smp_next[ch];
            prod_reg[ch] <= prod_next[ch];
            rem_reg[ch]  <= rem_next[ch];
            dq_reg[ch]   <= dq_next[ch];
            sx_reg[ch]   <= sx_next[ch];
            sr_reg[ch]   <= sr_next[ch];
            root_reg[ch] <= root_next[ch];
            rms_reg[ch]  <= rms_next[ch];
        end
    end

    // window store: read the oldest entry and overwrite it in the same cycle
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_rd_reg     <= win_mem[p_eff];
            old_vld_reg    <= vld_reg[p_eff];
            win_mem[p_eff] <= {s_right_in, s_left_in};
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rms_left  = rms_reg[0];
    assign m_rms_right = rms_reg[1];

endmodule
